/* hdl/lcr_pkg.sv */
// Shared constants for the combined shuffled random number generator.
package lcr_pkg;

  // Width of generator states, table entries and deviates.
  localparam int VAL_W = 31;
  localparam int MUL_W = 16;

  // Shuffle table size and warm-up length on reseed.
  localparam int TABLE_SIZE   = 32;
  localparam int WARMUP_STEPS = 8;
  localparam int TOTAL_STEPS  = TABLE_SIZE + WARMUP_STEPS;

  // Index and counter widths.
  localparam int IDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W = $clog2(TOTAL_STEPS + 1);

  // Item operations.
  localparam logic OP_DRAW   = 1'b0;
  localparam logic OP_RESEED = 1'b1;

  // Generator moduli and multipliers.
  localparam logic [VAL_W-1:0] MOD1 = 31'd2147483563;
  localparam logic [VAL_W-1:0] MOD2 = 31'd2147483399;
  localparam logic [MUL_W-1:0] MUL1 = 16'd40014;
  localparam logic [MUL_W-1:0] MUL2 = 16'd40692;

  // Reset value of the second generator and the top of the output range.
  localparam logic [VAL_W-1:0] SEED2_RESET = 31'd123456789;
  localparam logic [VAL_W-1:0] TOP1        = MOD1 - 31'd1;

  // Divisor that maps the previous output onto a table slot.
  localparam logic [VAL_W-1:0] SLOT_DIV =
    VAL_W'(64'(TOP1) / 64'(TABLE_SIZE) + 64'd1);

endpackage

/* hdl/lcr_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module lcr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/lcr_step.sv */
// Two-stage pipeline that advances both congruential generators by one step.
module lcr_step
  import lcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [VAL_W-1:0] x1,
  input  logic [VAL_W-1:0] x2,
  output logic [VAL_W-1:0] y1,
  output logic [VAL_W-1:0] y2,
  output logic             vld
);

  // Each modulus is two to the 31 minus a small constant, so the high part
  // of a product folds back in through a multiply by that constant.
  localparam int PROD_W = VAL_W + MUL_W;
  localparam logic [7:0] FOLD1 = 8'((33'd1 << VAL_W) - 33'(MOD1));
  localparam logic [7:0] FOLD2 = 8'((33'd1 << VAL_W) - 33'(MOD2));

  logic [PROD_W-1:0] prod1;
  logic [PROD_W-1:0] prod2;
  logic              prod_vld;
  logic [VAL_W:0]    sum1;
  logic [VAL_W:0]    sum2;

  // First stage: full products.
  always_ff @(posedge clk) begin
    if (go) begin
      prod1 <= PROD_W'(x1) * PROD_W'(MUL1);
      prod2 <= PROD_W'(x2) * PROD_W'(MUL2);
    end
  end

  // Fold the high part; the sum stays below twice the modulus.
  always_comb begin
    sum1 = (VAL_W+1)'(prod1[VAL_W-1:0]) +
           (VAL_W+1)'(prod1[PROD_W-1:VAL_W]) * (VAL_W+1)'(FOLD1);
    sum2 = (VAL_W+1)'(prod2[VAL_W-1:0]) +
           (VAL_W+1)'(prod2[PROD_W-1:VAL_W]) * (VAL_W+1)'(FOLD2);
  end

  // Second stage: one conditional subtract gives the residue.
  always_ff @(posedge clk) begin
    if (prod_vld) begin
      y1 <= (sum1 >= (VAL_W+1)'(MOD1)) ? VAL_W'(sum1 - (VAL_W+1)'(MOD1)) : VAL_W'(sum1);
      y2 <= (sum2 >= (VAL_W+1)'(MOD2)) ? VAL_W'(sum2 - (VAL_W+1)'(MOD2)) : VAL_W'(sum2);
    end
  end

  // Valid flags travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      vld      <= 1'b0;
    end else begin
      prod_vld <= go;
      vld      <= prod_vld;
    end
  end

endmodule

/* hdl/lecuyer_combined_shuffled_rng.sv */
// Combined shuffled random number generator: two congruential generators and a shuffle table.
// A draw item passes through the slot estimate, then the slot correction and table read,
// then the write-back that registers the result and raises the done strobe.
// A reseed item first runs the TOTAL_STEPS generator steps one after another through the
// step pipeline, then goes on as a draw.
// The next item is accepted in the cycle that shows the done strobe; the receiver cannot stall.
// Synchronous reset restores the generators and marks every table entry as zero.
module lecuyer_combined_shuffled_rng
  import lcr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic             op,
  input  logic [VAL_W-1:0] seed,
  output logic [VAL_W-1:0] value,
  output logic             done
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SEED  = 5'b00010,
    S_DIV   = 5'b00100,
    S_READ  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  // Reciprocal of the slot divisor scaled by two to the VAL_W. The quotient it
  // gives is never high and at most one low, so one compare settles it.
  localparam int QUO_W = IDX_W + 2;
  localparam int EST_W = VAL_W + QUO_W;
  localparam logic [QUO_W-1:0] SLOT_RCP = QUO_W'((64'd1 << VAL_W) / 64'(SLOT_DIV));

  state_t                state;
  logic [VAL_W-1:0]      g1;
  logic [VAL_W-1:0]      g2;
  logic [VAL_W-1:0]      last_out;
  logic [CNT_W-1:0]      cnt;
  logic [VAL_W-1:0]      rem;
  logic [QUO_W-1:0]      quo;
  logic [TABLE_SIZE-1:0] valid_bits;

  logic [VAL_W-1:0] seed_fix;
  logic             step_go;
  logic [VAL_W-1:0] step_x1;
  logic [VAL_W-1:0] step_x2;
  logic [VAL_W-1:0] step_y1;
  logic [VAL_W-1:0] step_y2;
  logic             step_vld;
  logic [QUO_W-1:0] quo_est;
  logic [VAL_W-1:0] slot_rem;
  logic [QUO_W-1:0] quo_fix;
  logic [IDX_W-1:0] idx;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [VAL_W-1:0] ram_rdata;
  logic [VAL_W-1:0] tbl;
  logic [VAL_W-1:0] mixed;
  logic             fill_slot;

  assign busy     = (state != S_IDLE);
  assign seed_fix = (seed == '0) ? VAL_W'(1) : seed;

  // Quotient estimate by the scaled reciprocal.
  assign quo_est = QUO_W'((EST_W'(rem) * EST_W'(SLOT_RCP)) >> VAL_W);

  // One correction step, then the clamp to the table.
  assign slot_rem = rem - VAL_W'(EST_W'(quo) * EST_W'(SLOT_DIV));
  assign quo_fix  = quo + QUO_W'(slot_rem >= SLOT_DIV);
  assign idx = (quo_fix >= QUO_W'(TABLE_SIZE)) ? IDX_W'(TABLE_SIZE - 1) : quo_fix[IDX_W-1:0];

  // Seed steps below the table size fill a slot.
  assign fill_slot = (cnt < CNT_W'(TABLE_SIZE));

  // Generator step requests and table writes.
  always_comb begin
    step_go   = 1'b0;
    step_x1   = g1;
    step_x2   = g2;
    ram_we    = 1'b0;
    ram_waddr = idx;
    case (state)
      S_IDLE: begin
        if (start) begin
          step_go = 1'b1;
          step_x1 = (op == OP_RESEED) ? seed_fix : g1;
        end
      end
      S_SEED: begin
        if (step_vld) begin
          step_go   = 1'b1;
          step_x1   = step_y1;
          ram_we    = fill_slot;
          ram_waddr = cnt[IDX_W-1:0];
        end
      end
      S_WRITE: begin
        ram_we = 1'b1;
      end
      default: begin
        step_go = 1'b0;
      end
    endcase
  end

  // Shuffle table entry combined with the second generator.
  always_comb begin
    tbl = valid_bits[idx] ? ram_rdata : '0;
    if (tbl > step_y2) begin
      mixed = tbl - step_y2;
    end else begin
      mixed = VAL_W'((VAL_W+1)'(tbl) + (VAL_W+1)'(TOP1) - (VAL_W+1)'(step_y2));
    end
  end

  lcr_step u_step (
    .clk (clk),
    .rst (rst),
    .go  (step_go),
    .x1  (step_x1),
    .x2  (step_x2),
    .y1  (step_y1),
    .y2  (step_y2),
    .vld (step_vld)
  );

  lcr_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (step_y1),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // Sequencer for reseed, slot estimate, table read and write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      g1         <= VAL_W'(1);
      g2         <= SEED2_RESET;
      last_out   <= '0;
      valid_bits <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (op == OP_RESEED) begin
              g1    <= seed_fix;
              g2    <= seed_fix;
              cnt   <= CNT_W'(TOTAL_STEPS - 1);
              state <= S_SEED;
            end else begin
              rem   <= last_out;
              state <= S_DIV;
            end
          end
        end
        S_SEED: begin
          if (step_vld) begin
            if (fill_slot) begin
              valid_bits[cnt[IDX_W-1:0]] <= 1'b1;
            end
            if (cnt == '0) begin
              last_out <= step_y1;
              rem      <= step_y1;
              state    <= S_DIV;
            end else begin
              cnt <= cnt - CNT_W'(1);
            end
          end
        end
        S_DIV: begin
          quo   <= quo_est;
          state <= S_READ;
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          g1              <= step_y1;
          g2              <= step_y2;
          last_out        <= mixed;
          value           <= mixed;
          done            <= 1'b1;
          valid_bits[idx] <= 1'b1;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/lecuyer_combined_shuffled_rng_test.sv */
// Self-checking testbench for the combined shuffled random number generator.
module lecuyer_combined_shuffled_rng_test
  import lcr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Schrage decomposition constants of both generators.
  localparam longint QUO1 = 53668;
  localparam longint QUO2 = 52774;
  localparam longint REM1 = 12211;
  localparam longint REM2 = 3791;

  // Run length guard and items per random phase.
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PHASE_ITEMS  = 650;
  localparam int SETTLE_CYCLES = 100;

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  logic             op    = 1'b0;
  logic [VAL_W-1:0] seed  = '0;
  logic             busy;
  logic [VAL_W-1:0] value;
  logic             done;

  // Predicted generator state.
  logic [VAL_W-1:0] gen_first;
  logic [VAL_W-1:0] gen_second;
  logic [VAL_W-1:0] prev_deviate;
  logic [VAL_W-1:0] slots [TABLE_SIZE];

  // Deviates predicted but not yet seen, oldest first.
  logic [VAL_W-1:0] pending_deviates [$];

  int idle_pct       = 0;
  int failures       = 0;
  int draws_sent     = 0;
  int reseeds_sent   = 0;
  int deviates_seen  = 0;
  int cycles         = 0;

  lecuyer_combined_shuffled_rng uut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .op    (op),
    .seed  (seed),
    .value (value),
    .done  (done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One multiplicative congruential step without overflow.
  function automatic longint schrage_step(longint x, longint a, longint q, longint r,
                                          longint m);
    longint k;
    longint t;
    k = x / q;
    t = a * (x - k * q) - k * r;
    if (t < 0) t += m;
    return t;
  endfunction

  // Advances the predicted state by one item and returns the deviate it yields.
  function automatic logic [VAL_W-1:0] predict_deviate(bit reseed, logic [VAL_W-1:0] s);
    longint x;
    longint idx;
    longint dev;
    if (reseed) begin
      x = (s == '0) ? 1 : longint'(s);
      gen_second = VAL_W'(x);
      for (int i = TOTAL_STEPS - 1; i >= 0; i--) begin
        x = schrage_step(x, MUL1, QUO1, REM1, MOD1);
        if (i < TABLE_SIZE) slots[i] = VAL_W'(x);
      end
      gen_first    = VAL_W'(x);
      prev_deviate = slots[0];
    end
    gen_first  = VAL_W'(schrage_step(longint'(gen_first), MUL1, QUO1, REM1, MOD1));
    gen_second = VAL_W'(schrage_step(longint'(gen_second), MUL2, QUO2, REM2, MOD2));

    // Previous output picks the slot; clamp kept as a safeguard.
    idx = longint'(prev_deviate) / longint'(SLOT_DIV);
    if (idx >= TABLE_SIZE) idx = TABLE_SIZE - 1;

    dev = longint'(slots[idx]) - longint'(gen_second);
    slots[idx] = gen_first;
    if (dev < 1) dev += longint'(TOP1);
    prev_deviate = VAL_W'(dev);
    return prev_deviate;
  endfunction

  // Sends one item with random gaps, then records its predicted deviate.
  task automatic issue_item(input bit reseed, input logic [VAL_W-1:0] s);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      op    <= 1'($urandom_range(1));
      seed  <= VAL_W'($urandom);
      @(negedge clk);
    end
    start <= 1'b1;
    op    <= reseed;
    seed  <= s;
    do @(posedge clk); while (busy);
    pending_deviates.push_back(predict_deviate(reseed, s));
    if (reseed) reseeds_sent++;
    else draws_sent++;
  endtask

  // Holds the sender off until every predicted deviate has come out.
  task automatic drain_pending();
    @(negedge clk);
    start <= 1'b0;
    while (pending_deviates.size() != 0) @(posedge clk);
  endtask

  // Seeds that favor zero, small values and the neighborhoods of both moduli.
  function automatic logic [VAL_W-1:0] pick_seed();
    case ($urandom_range(5))
      0: return VAL_W'($urandom_range(15));
      1: return VAL_W'($urandom_range(32'h7FFFFFFF, 32'(MOD1) - 4));
      2: return VAL_W'($urandom_range(32'(MOD2) + 4, 32'(MOD2) - 4));
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // Draws straight out of reset, with the table still all zeros.
  task automatic test_reset_state();
    for (int i = 0; i < 4; i++) issue_item(OP_DRAW, {VAL_W{1'b1}});
  endtask

  // Reseeds at zero, one, around both moduli and at the top of the field.
  task automatic test_seed_corners();
    logic [VAL_W-1:0] corners [10];
    corners = '{31'd0, 31'd1, MOD1 - 31'd1, MOD1, MOD1 + 31'd1, MOD2 - 31'd1, MOD2,
                31'h7FFFFFFF, 31'h2AAAAAAA, 31'h55555555};
    foreach (corners[i]) begin
      issue_item(OP_RESEED, corners[i]);
      issue_item(OP_DRAW, ~corners[i]);
    end
    drain_pending();
  endtask

  // Random mix of draws and reseeds under a given sender gap rate.
  task automatic test_random_traffic(input int gap_pct, input int n);
    idle_pct = gap_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) issue_item(OP_RESEED, pick_seed());
      else issue_item(OP_DRAW, VAL_W'($urandom));
      if (i == n / 2) drain_pending();
    end
    drain_pending();
  endtask

  // Compares each strobed deviate with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_deviates.size() == 0) begin
        $error("value: deviate %0d arrived with nothing expected", value);
        failures++;
      end else begin
        if (value !== pending_deviates[0]) begin
          $error("value mismatch: expected %0d, actual %0d", pending_deviates[0], value);
          failures++;
        end
        void'(pending_deviates.pop_front());
        deviates_seen++;
      end
    end
  end

  // Ends a hung run.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("lecuyer_combined_shuffled_rng regression: fail");
    $finish;
  end

  initial begin
    gen_first    = VAL_W'(1);
    gen_second   = SEED2_RESET;
    prev_deviate = '0;
    foreach (slots[i]) slots[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_seed_corners();
    test_random_traffic(21, PHASE_ITEMS);
    test_random_traffic(85, PHASE_ITEMS);
    test_random_traffic(0, PHASE_ITEMS);

    drain_pending();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d draws and %0d reseeds; %0d deviates checked in %0d cycles.",
             draws_sent, reseeds_sent, deviates_seen, cycles);
    $display("Seeds included zero, both moduli and their neighbors; gap rates 21, 85, 0.");
    if (failures == 0)
      $display("lecuyer_combined_shuffled_rng regression: pass");
    else
      $display("lecuyer_combined_shuffled_rng regression: fail");
    $finish;
  end

endmodule
